// ===== hdl/cia_pkg.sv =====
// Shared types and constants for the command ID allocator.
// No dependencies; compile first.
package cia_pkg;

	localparam int CID_W      = 8;
	localparam int STATE_W    = 8;
	localparam int CODE_W     = 2;
	localparam int TASK_DEPTH = 256;

	// command codes
	localparam logic [1:0] CMD_ALLOC   = 2'd0;
	localparam logic [1:0] CMD_RELEASE = 2'd1;
	localparam logic [1:0] CMD_UPDATE  = 2'd2;

	// result codes
	localparam logic [CODE_W-1:0] RC_OK    = 2'd0;
	localparam logic [CODE_W-1:0] RC_EMPTY = 2'd1;
	localparam logic [CODE_W-1:0] RC_SYNC  = 2'd2;
	localparam logic [CODE_W-1:0] RC_FULL  = 2'd3;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	// request beat as seen by the datapath
	typedef struct packed {
		logic [1:0]         cmd;
		logic [CID_W-1:0]   cid;
		logic [STATE_W-1:0] expected_state;
		logic [STATE_W-1:0] next_state;
		logic [STATE_W-1:0] new_status;
	} req_t;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic commit;
	} ctl_t;

	// datapath -> controller
	typedef struct packed {
		logic out_full;
	} sts_t;

endpackage

// ===== hdl/cia_ifs.sv =====
// Valid/ready channel interfaces for the request and response sides.
// Depends on nothing; compile after cia_pkg.
interface cia_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] cmd;
	logic [7:0] cid;
	logic [7:0] expected_state;
	logic [7:0] next_state;
	logic [7:0] new_status;

	modport source (output valid, cmd, cid, expected_state, next_state, new_status,
		input ready);
	modport sink (input valid, cmd, cid, expected_state, next_state, new_status,
		output ready);
endinterface

interface cia_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] granted_cid;
	logic [1:0] result_code;

	modport source (output valid, granted_cid, result_code, input ready);
	modport sink (input valid, granted_cid, result_code, output ready);
endinterface

// ===== hdl/cia_ctrl.sv =====
// Sequencer for the allocator: accept, then execute and retire one beat.
// Depends on cia_pkg.
module cia_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	input  logic          rsp_ready,
	input  cia_pkg::sts_t sts,
	output logic          req_ready,
	output cia_pkg::ctl_t ctl
);
	import cia_pkg::*;

	state_t state_q, state_d;
	logic   slot_free;

	assign slot_free = !sts.out_full || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				if (slot_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		req_ready  = 1'b0;
		ctl.load   = 1'b0;
		ctl.commit = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				ctl.load  = req_valid;
			end
			ST_EXEC: begin
				ctl.commit = slot_free;
			end
			default: ;
		endcase
	end

endmodule

// ===== hdl/cia_dp.sv =====
// Datapath: free-ID ring, task state/status tables, pointers, result register.
// Depends on cia_pkg.
module cia_dp #(
	parameter int ID_COUNT = 256
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  cia_pkg::ctl_t               ctl,
	input  cia_pkg::req_t               req,
	input  logic                        rsp_ready,
	output cia_pkg::sts_t               sts,
	output logic                        rsp_valid,
	output logic [cia_pkg::CID_W-1:0]   granted_cid,
	output logic [cia_pkg::CODE_W-1:0]  result_code
);
	import cia_pkg::*;

	localparam int AW = (ID_COUNT > 1) ? $clog2(ID_COUNT) : 1;
	localparam logic [AW-1:0] LAST_SLOT = AW'(ID_COUNT - 1);

	// memories
	logic [CID_W-1:0]   ring_mem   [ID_COUNT];
	logic [STATE_W-1:0] task_mem   [TASK_DEPTH];
	logic [STATE_W-1:0] status_mem [TASK_DEPTH];
	logic [TASK_DEPTH-1:0] task_vld_q;

	// ring pointers: slot plus lap bit, i.e. modulo 2*ID_COUNT
	logic [AW-1:0] rd_slot_q, wr_slot_q;
	logic          rd_lap_q, wr_lap_q;
	logic          wr_done_q;  // every slot written at least once

	// latched request and registered reads
	req_t               req_q;
	logic [CID_W-1:0]   ring_rd_s1;
	logic               ring_hit_s1;
	logic [STATE_W-1:0] task_rd_s1;
	logic               task_hit_s1;

	// result register
	logic               rsp_valid_q;
	logic [CID_W-1:0]   granted_q;
	logic [CODE_W-1:0]  code_q;

	// execute stage
	logic               ring_empty, ring_full;
	logic [STATE_W-1:0] cur_state;
	logic               state_ok;
	logic               pop, push, st_wr, stat_wr;
	logic [CID_W-1:0]   granted_d;
	logic [CODE_W-1:0]  code_d;

	assign ring_empty = (rd_slot_q == wr_slot_q) && (rd_lap_q == wr_lap_q);
	assign ring_full  = (rd_slot_q == wr_slot_q) && (rd_lap_q != wr_lap_q);
	assign cur_state  = task_hit_s1 ? task_rd_s1 : '0;
	assign state_ok   = (cur_state == req_q.expected_state) ||
		(cur_state inside {[8'd0:8'd2]});

	always_comb begin
		pop       = 1'b0;
		push      = 1'b0;
		st_wr     = 1'b0;
		stat_wr   = 1'b0;
		granted_d = '0;
		code_d    = RC_OK;
		case (req_q.cmd)
			CMD_ALLOC: begin
				if (ring_empty) begin
					code_d = RC_EMPTY;
				end else begin
					pop       = 1'b1;
					granted_d = ring_hit_s1 ? ring_rd_s1 : CID_W'(rd_slot_q);
				end
			end
			CMD_RELEASE: begin
				if (ring_full) begin
					code_d = RC_FULL;
				end else begin
					push = 1'b1;
				end
			end
			CMD_UPDATE: begin
				stat_wr = 1'b1;
				if (state_ok) begin
					st_wr = 1'b1;
				end else begin
					code_d = RC_SYNC;
				end
			end
			default: ;
		endcase
	end

	// request latch and synchronous reads at accept
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			req_q       <= req;
			ring_rd_s1  <= ring_mem[rd_slot_q];
			task_rd_s1  <= task_mem[req.cid];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_hit_s1 <= 1'b0;
			task_hit_s1 <= 1'b0;
		end else if (ctl.load) begin
			ring_hit_s1 <= wr_done_q || (rd_slot_q < wr_slot_q);
			task_hit_s1 <= task_vld_q[req.cid];
		end
	end

	// memory writes at commit
	always_ff @(posedge clk) begin
		if (ctl.commit && push) ring_mem[wr_slot_q] <= req_q.cid;
		if (ctl.commit && st_wr) task_mem[req_q.cid] <= req_q.next_state;
		if (ctl.commit && stat_wr) status_mem[req_q.cid] <= req_q.new_status;
	end

	// pointers and valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_slot_q  <= '0;
			rd_lap_q   <= 1'b0;
			wr_slot_q  <= '0;
			wr_lap_q   <= 1'b1;
			wr_done_q  <= 1'b0;
			task_vld_q <= '0;
		end else if (ctl.commit) begin
			if (pop) begin
				if (rd_slot_q == LAST_SLOT) begin
					rd_slot_q <= '0;
					rd_lap_q  <= !rd_lap_q;
				end else begin
					rd_slot_q <= rd_slot_q + 1'b1;
				end
			end
			if (push) begin
				if (wr_slot_q == LAST_SLOT) begin
					wr_slot_q <= '0;
					wr_lap_q  <= !wr_lap_q;
					wr_done_q <= 1'b1;
				end else begin
					wr_slot_q <= wr_slot_q + 1'b1;
				end
			end
			if (st_wr) task_vld_q[req_q.cid] <= 1'b1;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (ctl.commit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.commit) begin
			granted_q <= granted_d;
			code_q    <= code_d;
		end
	end

	assign sts.out_full = rsp_valid_q;
	assign rsp_valid    = rsp_valid_q;
	assign granted_cid  = granted_q;
	assign result_code  = code_q;

endmodule

// ===== hdl/command_id_allocator_with_task_states.sv =====
// Command ID allocator: a ring of free IDs plus a per-ID task state table.
// Depends on cia_pkg, cia_ifs, cia_ctrl and cia_dp.
//
// Hands out command IDs from a free ring that comes out of reset full with
// IDs 0 to ID_COUNT-1 in order, takes them back on release, and keeps an
// 8-bit state and status per ID. Every request beat gives exactly one
// response beat. Allocate pops the oldest free ID (ring empty -> code 1),
// release pushes the given ID (ring full -> code 3, push dropped), update
// always writes the status and moves the state to next_state when the current
// state equals expected_state or is 0, 1 or 2 (otherwise code 2, state kept).
// Each beat is accepted in the idle state, which issues the synchronous reads
// of the ring and task-state memories; the execute state decides, writes back
// and loads the response register, then returns to idle for the next beat.
// The response register sits between the sides, so a new request is accepted
// while a response is still waiting; execution holds only if the previous
// response has not been taken by then. No clearing pass after reset: the ring
// tracks which slots have been written since reset and the task table has a
// valid bit per entry, so the block is ready as soon as reset is released.
module command_id_allocator_with_task_states #(
	parameter int ID_COUNT = 256
) (
	input logic      clk,
	input logic      arst_n,
	cia_req_if.sink  req,
	cia_rsp_if.source rsp
);
	import cia_pkg::*;

	ctl_t ctl;
	sts_t sts;
	req_t req_beat;

	assign req_beat.cmd            = req.cmd;
	assign req_beat.cid            = req.cid;
	assign req_beat.expected_state = req.expected_state;
	assign req_beat.next_state     = req.next_state;
	assign req_beat.new_status     = req.new_status;

	// sequencer
	cia_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.rsp_ready (rsp.ready),
		.sts       (sts),
		.req_ready (req.ready),
		.ctl       (ctl)
	);

	// ring, tables and response register
	cia_dp #(
		.ID_COUNT (ID_COUNT)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.req         (req_beat),
		.rsp_ready   (rsp.ready),
		.sts         (sts),
		.rsp_valid   (rsp.valid),
		.granted_cid (rsp.granted_cid),
		.result_code (rsp.result_code)
	);

`ifndef SYNTHESIS
	// one beat in flight: an accept is never followed by another next cycle
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request accepted back to back");

	// a response only appears as the result of an execute cycle
	a_rsp_from_commit: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !$past(rsp.valid) |-> $past(ctl.commit))
		else $error("response without commit");

	// a failed command carries no ID: granted_cid reads zero
	a_grant_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.result_code != RC_OK |-> rsp.granted_cid == '0)
		else $error("granted ID on failed command");

	// execute never overwrites a response still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.commit |-> !rsp.valid || rsp.ready)
		else $error("response overwritten");
`endif

endmodule
